[rtl/core/tnst_pkg.sv]
// Shared types and constants for the top-N score table.
package tnst_pkg;

	// Default parameter values
	localparam int unsigned DEPTH_DEF    = 10;
	localparam int unsigned TAG_BITS_DEF = 16;

	// Field widths
	localparam int unsigned SCORE_W = 32;
	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned DAY_W   = 5;
	localparam int unsigned RANK_W  = 4;

	// Operation codes carried in s_tuser
	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_QUERY  = 1'b1
	} op_t;

	// Date limits and fallback date
	localparam logic [15:0] YEAR_RAW_MAX   = 16'd8099;
	localparam logic [7:0]  MONTH_RAW_MAX  = 8'd11;
	localparam logic [7:0]  DAY_RAW_MAX    = 8'd31;
	localparam logic [7:0]  DAY_SHORT_MAX  = 8'd30;
	localparam logic [7:0]  DAY_FEB_MAX    = 8'd28;
	localparam int unsigned LEAP_PERIOD    = 4;
	localparam logic [YEAR_W-1:0]  YEAR_BASE     = 14'd1900;
	localparam logic [YEAR_W-1:0]  YEAR_DEFAULT  = 14'd1995;
	localparam logic [MONTH_W-1:0] MONTH_DEFAULT = 4'd12;
	localparam logic [DAY_W-1:0]   DAY_DEFAULT   = 5'd25;

	// Zero-based month codes of short months
	localparam logic [7:0] MON_FEB = 8'd1;
	localparam logic [7:0] MON_APR = 8'd3;
	localparam logic [7:0] MON_JUN = 8'd5;
	localparam logic [7:0] MON_SEP = 8'd8;
	localparam logic [7:0] MON_NOV = 8'd10;

	localparam logic [SCORE_W-1:0] SCORE_CAP_RESET = 32'hFFFF_FFFF;

	// Sanitized calendar date
	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
	} date_t;

	// Table write command from the sequencer
	typedef struct packed {
		logic copy;   // entry[wr_idx] <= entry[rd_idx]
		logic write;  // entry[wr_idx] <= new entry
	} tbl_cmd_t;

endpackage

[rtl/core/tnst_sanitize.sv]
// Score clamp and date check for incoming transactions.
module tnst_sanitize (
	input  logic                          is_query,
	input  logic [tnst_pkg::SCORE_W-1:0]  raw_score,
	input  logic [tnst_pkg::SCORE_W-1:0]  score_cap,
	input  logic [15:0]                   year_offset,
	input  logic [7:0]                    month_index,
	input  logic [7:0]                    day_of_month,
	output logic [tnst_pkg::SCORE_W-1:0]  key_score,
	output tnst_pkg::date_t               date
);

	logic range_bad;
	logic short_bad;
	logic feb_bad;
	logic date_good;
	logic [1:0] leap_rem;

	// queries compare the raw score, inserts the clamped one
	assign key_score = (!is_query && (raw_score > score_cap)) ? score_cap : raw_score;

	assign leap_rem  = 2'(year_offset % tnst_pkg::LEAP_PERIOD);
	assign range_bad = (year_offset > tnst_pkg::YEAR_RAW_MAX)
		|| (month_index > tnst_pkg::MONTH_RAW_MAX)
		|| (day_of_month > tnst_pkg::DAY_RAW_MAX);
	assign short_bad = (day_of_month > tnst_pkg::DAY_SHORT_MAX)
		&& ((month_index == tnst_pkg::MON_FEB) || (month_index == tnst_pkg::MON_APR)
		|| (month_index == tnst_pkg::MON_JUN) || (month_index == tnst_pkg::MON_SEP)
		|| (month_index == tnst_pkg::MON_NOV));
	// Feb 29/30 only in years divisible by four; Feb 30 slips through then
	assign feb_bad   = (day_of_month > tnst_pkg::DAY_FEB_MAX)
		&& (month_index == tnst_pkg::MON_FEB) && (leap_rem != 2'd0);
	assign date_good = !range_bad && !short_bad && !feb_bad;

	always_comb begin
		if (date_good) begin
			date.year  = tnst_pkg::YEAR_W'(year_offset) + tnst_pkg::YEAR_BASE;
			date.month = tnst_pkg::MONTH_W'(month_index) + tnst_pkg::MONTH_W'(1);
			date.day   = tnst_pkg::DAY_W'(day_of_month);
		end else begin
			date.year  = tnst_pkg::YEAR_DEFAULT;
			date.month = tnst_pkg::MONTH_DEFAULT;
			date.day   = tnst_pkg::DAY_DEFAULT;
		end
	end

endmodule

[rtl/core/tnst_table.sv]
// Entry storage: one read port, one write port with copy-down.
module tnst_table #(
	parameter int unsigned DEPTH    = tnst_pkg::DEPTH_DEF,
	parameter int unsigned TAG_BITS = tnst_pkg::TAG_BITS_DEF,
	parameter int unsigned IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tnst_pkg::tbl_cmd_t            cmd,
	input  logic [IDX_W-1:0]              rd_idx,
	input  logic [IDX_W-1:0]              wr_idx,
	input  logic [tnst_pkg::SCORE_W-1:0]  new_score,
	input  tnst_pkg::date_t               new_date,
	input  logic [TAG_BITS-1:0]           new_tag,
	output logic [tnst_pkg::SCORE_W-1:0]  rd_score
);

	logic [tnst_pkg::SCORE_W-1:0] score_q [DEPTH];
	tnst_pkg::date_t              date_q  [DEPTH];
	logic [TAG_BITS-1:0]          tag_q   [DEPTH];

	assign rd_score = score_q[rd_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				score_q[i]      <= '0;
				date_q[i].year  <= tnst_pkg::YEAR_DEFAULT;
				date_q[i].month <= tnst_pkg::MONTH_DEFAULT;
				date_q[i].day   <= tnst_pkg::DAY_DEFAULT;
				tag_q[i]        <= '0;
			end
		end else if (cmd.write) begin
			score_q[wr_idx] <= new_score;
			date_q[wr_idx]  <= new_date;
			tag_q[wr_idx]   <= new_tag;
		end else if (cmd.copy) begin
			score_q[wr_idx] <= score_q[rd_idx];
			date_q[wr_idx]  <= date_q[rd_idx];
			tag_q[wr_idx]   <= tag_q[rd_idx];
		end
	end

endmodule

[rtl/core/top_n_score_table_top.sv]
// Top level of the top-N score table: sequencer, config register, result register.
//
//  channel   dir  handshake         payload
//  s_*       in   tvalid/tready     tdata: fields below, tuser: opcode
//  m_*       out  tvalid/tready     tdata: result fields below
//  cfg_*     in   cfg_we            cfg_wdata: score cap
//
// Steps: the idle state accepts, then a search walks the table one entry per
// cycle through a single comparator, then for a stored insert the shift state
// copies entries down from the last one and writes the new entry at its slot,
// then the done state loads the result register. A query or a miss skips the
// copy-down; an explicit-slot insert skips the search, and a refused one also
// skips the copy-down.
// Reset: arst_n clears the sequencer, the result register and the table to
// score 0, date 1995-12-25, empty tag; the score cap resets to all ones.
// Stalls: s_tready is high only while the sequencer is idle; a finished
// result waits in the output register while the next transaction comes in,
// and the done step holds while that register is full and not being taken.
module top_n_score_table_top #(
	parameter int unsigned TABLE_DEPTH = tnst_pkg::DEPTH_DEF,
	parameter int unsigned TAG_BITS    = tnst_pkg::TAG_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// s_tdata: score[31:0], year_offset[47:32], month_index[55:48],
	// day_of_month[63:56], name_tag[79:64], use_position[80], position[84:81]
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [87:0] s_tdata,
	input  logic [0:0]  s_tuser,   // opcode[0]
	// m_tdata: accepted[0], rank[4:1], stored_score[36:5], stored_year[50:37],
	// stored_month[54:51], stored_day[59:55]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SHIFT,
		ST_DONE
	} state_t;

	// input fields
	logic [31:0] in_score;
	logic [15:0] in_year;
	logic [7:0]  in_month;
	logic [7:0]  in_day;
	logic [15:0] in_tag;
	logic        in_use_pos;
	logic [3:0]  in_pos;
	logic        in_query;

	assign in_score   = s_tdata[31:0];
	assign in_year    = s_tdata[47:32];
	assign in_month   = s_tdata[55:48];
	assign in_day     = s_tdata[63:56];
	assign in_tag     = s_tdata[79:64];
	assign in_use_pos = s_tdata[80];
	assign in_pos     = s_tdata[84:81];
	assign in_query   = (tnst_pkg::op_t'(s_tuser[0]) == tnst_pkg::OP_QUERY);

	state_t state_q;
	logic [tnst_pkg::SCORE_W-1:0] score_cap_q;
	logic                         query_q;
	logic [tnst_pkg::SCORE_W-1:0] key_q;
	tnst_pkg::date_t              date_q;
	logic [TAG_BITS-1:0]          tag_q;
	logic [IDX_W-1:0]             idx_q;
	logic [IDX_W-1:0]             slot_q;
	logic                         ok_q;

	// result register
	logic                         m_valid_q;
	logic                         acc_q;
	logic [tnst_pkg::RANK_W-1:0]  rank_q;
	logic [tnst_pkg::SCORE_W-1:0] oscore_q;
	tnst_pkg::date_t              odate_q;

	logic [tnst_pkg::SCORE_W-1:0] key_score;
	tnst_pkg::date_t              date_in;
	logic [tnst_pkg::SCORE_W-1:0] rd_score;
	logic [IDX_W-1:0]             rd_idx;
	tnst_pkg::tbl_cmd_t           tbl_cmd;
	logic                         beats;
	logic                         in_fire;
	logic                         pos_ok;
	logic                         res_load;

	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign pos_ok   = ({1'b0, in_pos} < 5'(TABLE_DEPTH));
	// result register takes a new result when empty or emptying this cycle
	assign res_load = (state_q == ST_DONE) && (!m_valid_q || m_tready);

	tnst_sanitize u_sanitize (
		.is_query     (in_query),
		.raw_score    (in_score),
		.score_cap    (score_cap_q),
		.year_offset  (in_year),
		.month_index  (in_month),
		.day_of_month (in_day),
		.key_score    (key_score),
		.date         (date_in)
	);

	// copy-down reads the entry above the one being written
	assign rd_idx = (state_q == ST_SHIFT) ? ((idx_q == '0) ? '0 : idx_q - IDX_W'(1)) : idx_q;

	always_comb begin
		tbl_cmd.copy  = (state_q == ST_SHIFT) && (idx_q != slot_q);
		tbl_cmd.write = (state_q == ST_SHIFT) && (idx_q == slot_q);
	end

	tnst_table #(
		.DEPTH    (TABLE_DEPTH),
		.TAG_BITS (TAG_BITS),
		.IDX_W    (IDX_W)
	) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (tbl_cmd),
		.rd_idx    (rd_idx),
		.wr_idx    (idx_q),
		.new_score (key_q),
		.new_date  (date_q),
		.new_tag   (tag_q),
		.rd_score  (rd_score)
	);

	// the one shared comparator
	assign beats = (key_q > rd_score);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_cap_q <= tnst_pkg::SCORE_CAP_RESET;
		end else if (cfg_we) begin
			score_cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
			query_q   <= 1'b0;
			ok_q      <= 1'b0;
			idx_q     <= '0;
			slot_q    <= '0;
			acc_q     <= 1'b0;
			rank_q    <= '0;
			oscore_q  <= '0;
			odate_q   <= '0;
			key_q     <= '0;
			date_q    <= '0;
			tag_q     <= '0;
		end else begin
			if (res_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						query_q <= in_query;
						key_q   <= key_score;
						date_q  <= date_in;
						tag_q   <= TAG_BITS'(in_tag);
						if (!in_query && in_use_pos) begin
							ok_q   <= pos_ok;
							slot_q <= IDX_W'(in_pos);
							idx_q  <= LAST_IDX;
							state_q <= pos_ok ? ST_SHIFT : ST_DONE;
						end else begin
							ok_q    <= 1'b0;
							idx_q   <= '0;
							state_q <= ST_SEARCH;
						end
					end
				end
				ST_SEARCH: begin
					if (beats) begin
						ok_q   <= 1'b1;
						slot_q <= idx_q;
						if (query_q) begin
							state_q <= ST_DONE;
						end else begin
							idx_q   <= LAST_IDX;
							state_q <= ST_SHIFT;
						end
					end else if (idx_q == LAST_IDX) begin
						ok_q    <= 1'b0;
						state_q <= ST_DONE;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_SHIFT: begin
					if (idx_q == slot_q) begin
						state_q <= ST_DONE;
					end else begin
						idx_q <= idx_q - IDX_W'(1);
					end
				end
				ST_DONE: begin
					if (res_load) begin
						acc_q     <= ok_q;
						rank_q    <= ok_q ? tnst_pkg::RANK_W'(slot_q) : '0;
						oscore_q  <= query_q ? '0 : key_q;
						odate_q   <= query_q ? '0 : date_q;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'd0, odate_q.day, odate_q.month, odate_q.year, oscore_q, rank_q, acc_q};

	// a refused or missed transaction reports rank zero
	a_rank_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && !acc_q |-> rank_q == '0)
		else $error("rank nonzero on unaccepted result");

	// copy-down never walks above the insertion slot
	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SHIFT |-> idx_q >= slot_q)
		else $error("shift index below slot");

	// search index stays inside the table
	a_search_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEARCH |-> idx_q <= LAST_IDX)
		else $error("search index out of range");

	// a new result only comes from the done step
	a_load_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result loaded outside done step");

	// an accepted transaction leaves idle on the next edge
	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q != ST_IDLE)
		else $error("sequencer stayed idle after accept");

endmodule

[tb/score_table_monitor.sv]
// Channel monitor for the top-N score table: tracks the table, predicts each result, compares.
`timescale 1ns / 1ps

module score_table_monitor #(
	parameter int unsigned DEPTH    = tnst_pkg::DEPTH_DEF,
	parameter int unsigned TAG_BITS = tnst_pkg::TAG_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [87:0] s_tdata,
	input  logic [0:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	output int          errors,
	output int          pending,
	output int          n_stored,
	output int          n_refused,
	output int          n_bad_date,
	output int          n_queries,
	output int          n_ranked
);

	localparam int MAX_REPORTS = 40;

	// s_tdata layout, lowest field last
	typedef struct packed {
		logic [2:0]  pad;
		logic [3:0]  pos;
		logic        use_pos;
		logic [15:0] tag;
		logic [7:0]  day;
		logic [7:0]  month;
		logic [15:0] year;
		logic [31:0] score;
	} req_t;

	// m_tdata layout, lowest field last
	typedef struct packed {
		logic [3:0]                   pad;
		logic [tnst_pkg::DAY_W-1:0]   day;
		logic [tnst_pkg::MONTH_W-1:0] month;
		logic [tnst_pkg::YEAR_W-1:0]  year;
		logic [tnst_pkg::SCORE_W-1:0] score;
		logic [tnst_pkg::RANK_W-1:0]  rank;
		logic                         accepted;
	} outcome_t;

	typedef struct packed {
		logic [tnst_pkg::SCORE_W-1:0] score;
		tnst_pkg::date_t              when;
		logic [TAG_BITS-1:0]          tag;
	} entry_t;

	entry_t                       ranking [DEPTH];
	logic [tnst_pkg::SCORE_W-1:0] score_cap;
	outcome_t                     awaited_outcomes [$];

	function automatic int first_beaten(logic [tnst_pkg::SCORE_W-1:0] s);
		for (int i = 0; i < DEPTH; i++) begin
			if (s > ranking[i].score) return i;
		end
		return -1;
	endfunction

	function automatic bit date_valid(logic [15:0] y, logic [7:0] m, logic [7:0] d);
		if (y > tnst_pkg::YEAR_RAW_MAX || m > tnst_pkg::MONTH_RAW_MAX ||
			d > tnst_pkg::DAY_RAW_MAX) return 1'b0;
		if (d > tnst_pkg::DAY_SHORT_MAX)
			return !(m == tnst_pkg::MON_FEB || m == tnst_pkg::MON_APR ||
				m == tnst_pkg::MON_JUN || m == tnst_pkg::MON_SEP || m == tnst_pkg::MON_NOV);
		if (d > tnst_pkg::DAY_FEB_MAX && m == tnst_pkg::MON_FEB)
			return (y % tnst_pkg::LEAP_PERIOD) == 0;
		return 1'b1;
	endfunction

	// Applies one transaction to the table copy and returns the result it must give.
	function automatic outcome_t table_outcome(tnst_pkg::op_t op, req_t r);
		outcome_t                     o;
		logic [tnst_pkg::SCORE_W-1:0] sc;
		tnst_pkg::date_t              dt;
		int                           slot;
		o = '0;
		if (op == tnst_pkg::OP_QUERY) begin
			slot = first_beaten(r.score);
			n_queries++;
			if (slot >= 0) begin
				o.accepted = 1'b1;
				o.rank = slot[tnst_pkg::RANK_W-1:0];
				n_ranked++;
			end
			return o;
		end
		sc = (r.score > score_cap) ? score_cap : r.score;
		if (date_valid(r.year, r.month, r.day)) begin
			dt.year = r.year[tnst_pkg::YEAR_W-1:0] + tnst_pkg::YEAR_BASE;
			dt.month = r.month[tnst_pkg::MONTH_W-1:0] + tnst_pkg::MONTH_W'(1);
			dt.day = r.day[tnst_pkg::DAY_W-1:0];
		end else begin
			dt = {tnst_pkg::YEAR_DEFAULT, tnst_pkg::MONTH_DEFAULT, tnst_pkg::DAY_DEFAULT};
			n_bad_date++;
		end
		if (r.use_pos)
			slot = (r.pos < DEPTH) ? int'(r.pos) : -1;
		else
			slot = first_beaten(sc);
		if (slot >= 0) begin
			for (int i = DEPTH - 1; i > slot; i--) ranking[i] = ranking[i - 1];
			ranking[slot] = {sc, dt, r.tag[TAG_BITS-1:0]};
			o.accepted = 1'b1;
			o.rank = slot[tnst_pkg::RANK_W-1:0];
			n_stored++;
		end else begin
			n_refused++;
		end
		o.score = sc;
		o.year = dt.year;
		o.month = dt.month;
		o.day = dt.day;
		return o;
	endfunction

	task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		outcome_t got;
		outcome_t want;
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++)
				ranking[i] = {{tnst_pkg::SCORE_W{1'b0}}, tnst_pkg::YEAR_DEFAULT,
					tnst_pkg::MONTH_DEFAULT, tnst_pkg::DAY_DEFAULT, {TAG_BITS{1'b0}}};
			score_cap = tnst_pkg::SCORE_CAP_RESET;
			awaited_outcomes.delete();
			errors = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = outcome_t'(m_tdata);
				if (awaited_outcomes.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: result with nothing expected, expected none, got %h",
							$time, m_tdata);
				end else begin
					want = awaited_outcomes.pop_front();
					check_field("accepted", 32'(want.accepted), 32'(got.accepted));
					check_field("rank", 32'(want.rank), 32'(got.rank));
					check_field("stored_score", want.score, got.score);
					check_field("stored_year", 32'(want.year), 32'(got.year));
					check_field("stored_month", 32'(want.month), 32'(got.month));
					check_field("stored_day", 32'(want.day), 32'(got.day));
					check_field("tdata padding", 32'(want.pad), 32'(got.pad));
				end
			end
			// a transaction taken at this edge still sees the old cap
			if (s_tvalid && s_tready)
				awaited_outcomes.insert(awaited_outcomes.size(),
					table_outcome(tnst_pkg::op_t'(s_tuser[0]), req_t'(s_tdata)));
			if (cfg_we) score_cap = cfg_wdata;
		end
		pending = awaited_outcomes.size();
	end

endmodule

[tb/testbench.sv]
// Stimulus and verdict for the top-N score table; checking lives in score_table_monitor.
`timescale 1ns / 1ps

module testbench;

	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 320;
	localparam int HOLD_OFF     = 400;   // long receiver stall, fills the block
	localparam int QUIET_LIMIT  = 5000;  // cycles with no transaction at all
	localparam int SETTLE       = 2 * tnst_pkg::DEPTH_DEF + 3;

	logic        clk       = 1'b0;
	logic        arst_n;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [87:0] s_tdata   = '0;
	logic [0:0]  s_tuser   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [63:0] m_tdata;
	logic        cfg_we    = 1'b0;
	logic [31:0] cfg_wdata = '0;

	int errors, pending;
	int n_stored, n_refused, n_bad_date, n_queries, n_ranked;
	int n_settings;
	bit stall_req = 1'b0;

	always #6 clk = ~clk;

	top_n_score_table_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	score_table_monitor u_monitor (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.errors    (errors),
		.pending   (pending),
		.n_stored  (n_stored),
		.n_refused (n_refused),
		.n_bad_date(n_bad_date),
		.n_queries (n_queries),
		.n_ranked  (n_ranked)
	);

	// s_tdata fields from the lowest bit up, three zero bits on top
	function automatic logic [87:0] pack_req(logic [31:0] score, logic [15:0] year,
			logic [7:0] month, logic [7:0] day, logic [15:0] tag, logic use_pos,
			logic [3:0] pos);
		return {3'b000, pos, use_pos, tag, day, month, year, score};
	endfunction

	// Offer one transaction and hold it until the block takes it. Valid is only
	// raised here and only lowered by the gap and drain tasks, so it never gets
	// two updates in the same step.
	task automatic send(tnst_pkg::op_t op, logic [87:0] data);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= data;
		s_tuser <= op;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic pause_sender(int cycles);
		if (cycles > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (cycles - 1) @(negedge clk);
		end
	endtask

	// Pending is read at the falling edge, after the monitor has settled.
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic write_score_cap(logic [31:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	// Random transaction: scores drawn from bands that make ties, near-max
	// values and a spread of magnitudes; dates mostly near the validity edges.
	task automatic random_req(output tnst_pkg::op_t op, output logic [87:0] data);
		logic [31:0] score;
		logic [15:0] year;
		logic [7:0]  month, day;
		op = ($urandom_range(0, 9) < 3) ? tnst_pkg::OP_QUERY : tnst_pkg::OP_INSERT;
		case ($urandom_range(0, 3))
			0: score = $urandom;
			1: score = $urandom_range(0, 20);
			2: score = 32'hFFFF_FFFF - $urandom_range(0, 20);
			default: score = $urandom >> $urandom_range(0, 31);
		endcase
		if ($urandom_range(0, 9) < 6) begin
			case ($urandom_range(0, 2))
				0: year = 16'($urandom_range(0, tnst_pkg::YEAR_RAW_MAX));
				1: year = 16'($urandom_range(tnst_pkg::YEAR_RAW_MAX,
					tnst_pkg::YEAR_RAW_MAX + 1));
				default: year = 16'($urandom_range(0, 2047)) &
					~16'(tnst_pkg::LEAP_PERIOD - 1);
			endcase
			month = ($urandom_range(0, 3) == 0) ? tnst_pkg::MON_FEB :
				8'($urandom_range(0, tnst_pkg::MONTH_RAW_MAX + 1));
			day = $urandom_range(0, 1) ?
				8'($urandom_range(tnst_pkg::DAY_FEB_MAX, tnst_pkg::DAY_RAW_MAX + 1)) :
				8'($urandom_range(0, tnst_pkg::DAY_RAW_MAX));
		end else begin
			year = 16'($urandom);
			month = 8'($urandom);
			day = 8'($urandom);
		end
		data = pack_req(score, year, month, day, 16'($urandom),
			$urandom_range(0, 3) == 0, 4'($urandom));
	endtask

	// Receiver: its own changing ready pattern, plus one long hold-off on request.
	initial begin : rx_pace
		int  mode;
		int  left;
		bit  held;
		left = 0;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_req && !held) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_OFF) @(negedge clk);
			end
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(20, 200);
			end
			left--;
			case (mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= ((left % 8) < 3);
			endcase
		end
	end

	// Ends the run if no transaction of any kind happens for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				quiet = 0;
			else
				quiet++;
		end
		$display("testbench failed");
		$finish;
	end

	initial begin : stimulus
		tnst_pkg::op_t op;
		logic [87:0]   data;
		logic [31:0]   limits [PHASES];
		int            sent;
		int            burst;
		arst_n <= 1'b0;
		n_settings = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part, score cap still at its reset value, table all zero.
		// Query against an all-zero table: zero beats nothing, one beats slot 0.
		send(tnst_pkg::OP_QUERY, pack_req(32'd0, 16'd0, 8'd0, 8'd0, 16'd0, 1'b0, 4'd0));
		send(tnst_pkg::OP_QUERY, pack_req(32'd1, 16'd0, 8'd0, 8'd0, 16'd0, 1'b0, 4'd0));
		// Top score, earliest date, day zero passes
		send(tnst_pkg::OP_INSERT, pack_req(32'hFFFF_FFFF, 16'd0, 8'd0, 8'd0, 16'hFFFF,
			1'b0, 4'd0));
		// Latest legal date
		send(tnst_pkg::OP_INSERT, pack_req(32'd100, tnst_pkg::YEAR_RAW_MAX,
			tnst_pkg::MONTH_RAW_MAX, tnst_pkg::DAY_RAW_MAX, 16'h0001, 1'b0, 4'd0));
		// Year, month and day each one past the limit
		send(tnst_pkg::OP_INSERT, pack_req(32'd50, 16'(tnst_pkg::YEAR_RAW_MAX + 1), 8'd0,
			8'd1, 16'h0002, 1'b0, 4'd0));
		send(tnst_pkg::OP_INSERT, pack_req(32'd40, 16'd100,
			8'(tnst_pkg::MONTH_RAW_MAX + 1), 8'd1, 16'h0003, 1'b0, 4'd0));
		send(tnst_pkg::OP_INSERT, pack_req(32'd30, 16'd100, 8'd0,
			8'(tnst_pkg::DAY_RAW_MAX + 1), 16'h0004, 1'b0, 4'd0));
		// Day 31 in a thirty-day month
		send(tnst_pkg::OP_INSERT, pack_req(32'd20, 16'd100, tnst_pkg::MON_APR,
			tnst_pkg::DAY_RAW_MAX, 16'h0005, 1'b0, 4'd0));
		// February: 29th in a leap year, 29th off-leap, 30th in a leap year passes,
		// 31st refused, 28th off-leap fine
		send(tnst_pkg::OP_INSERT, pack_req(32'd60, 16'd100, tnst_pkg::MON_FEB, 8'd29,
			16'h0006, 1'b0, 4'd0));
		send(tnst_pkg::OP_INSERT, pack_req(32'd70, 16'd101, tnst_pkg::MON_FEB, 8'd29,
			16'h0007, 1'b0, 4'd0));
		send(tnst_pkg::OP_INSERT, pack_req(32'd80, 16'd104, tnst_pkg::MON_FEB, 8'd30,
			16'h0008, 1'b0, 4'd0));
		send(tnst_pkg::OP_INSERT, pack_req(32'd90, 16'd104, tnst_pkg::MON_FEB,
			tnst_pkg::DAY_RAW_MAX, 16'h0009, 1'b0, 4'd0));
		send(tnst_pkg::OP_INSERT, pack_req(32'd95, 16'd101, tnst_pkg::MON_FEB,
			tnst_pkg::DAY_FEB_MAX, 16'h000A, 1'b0, 4'd0));
		// Explicit slots: last legal, first out of range, highest code, top slot
		send(tnst_pkg::OP_INSERT, pack_req(32'd7, 16'd50, 8'd5, 8'd15, 16'h000B, 1'b1, 4'd9));
		send(tnst_pkg::OP_INSERT, pack_req(32'd8, 16'd50, 8'd5, 8'd15, 16'h000C, 1'b1,
			4'd10));
		send(tnst_pkg::OP_INSERT, pack_req(32'd9, 16'(tnst_pkg::YEAR_RAW_MAX + 1), 8'd5,
			8'd15, 16'h000D, 1'b1, 4'd15));
		send(tnst_pkg::OP_INSERT, pack_req(32'd5, 16'd60, 8'd6, 8'd6, 16'h000E, 1'b1, 4'd0));
		// Search insert that beats no entry, then a tie with an existing score
		send(tnst_pkg::OP_INSERT, pack_req(32'd0, 16'd70, 8'd7, 8'd7, 16'h000F, 1'b0, 4'd0));
		send(tnst_pkg::OP_INSERT, pack_req(32'd100, 16'd80, 8'd8, 8'd8, 16'h0010, 1'b0,
			4'd0));
		// Every field at all ones
		send(tnst_pkg::OP_INSERT, pack_req(32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF,
			1'b1, 4'hF));
		send(tnst_pkg::OP_QUERY, pack_req(32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF,
			1'b1, 4'hF));
		send(tnst_pkg::OP_QUERY, pack_req(32'd0, 16'd0, 8'd0, 8'd0, 16'd0, 1'b0, 4'd0));
		send(tnst_pkg::OP_QUERY, pack_req(32'd75, 16'd1, 8'd2, 8'd3, 16'h1234, 1'b1, 4'd3));

		// Random phases, each under its own clamp; both extremes included.
		limits[0] = 32'd0;
		limits[1] = $urandom;
		limits[2] = 32'd1000;
		limits[3] = 32'hFFFF_FFFF;
		limits[4] = $urandom >> 8;
		limits[5] = 32'h8000_0000;
		for (int ph = 0; ph < PHASES; ph++) begin
			drain_results();
			write_score_cap(limits[ph]);
			// Second phase: receiver holds off while the sender keeps offering.
			if (ph == 1) stall_req <= 1'b1;
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				burst = $urandom_range(1, 16);
				for (int k = 0; k < burst && sent < PHASE_ITEMS; k++) begin
					random_req(op, data);
					send(op, data);
					sent++;
				end
				// Phase 3 runs back to back; early phase 1 keeps pressing the stall.
				if (ph != 3 && !(ph == 1 && sent < 40))
					pause_sender($urandom_range(0, 12));
			end
		end

		drain_results();
		repeat (SETTLE) @(negedge clk);

		$display("Covered %0d inserts: %0d stored, %0d refused, %0d dates replaced.",
			n_stored + n_refused, n_stored, n_refused, n_bad_date);
		$display("Covered %0d queries (%0d ranked) over %0d score cap settings.",
			n_queries, n_ranked, n_settings);
		if (errors == 0 && pending == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule
